// ===== sv/tfsd_pkg.sv =====
package tfsd_pkg;

  // Fixed field widths
  localparam int ANGLE_W  = 16;
  localparam int ROLL_W   = 16;
  localparam int PITCH_W  = 15;
  localparam int YAW_W    = 16;
  localparam int ALPHA_W  = 17;
  localparam int BASE_W   = 15;
  localparam int THR_W    = 15;
  localparam int CONF_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_ANGLE_FRAC_BITS = 7;
  localparam int DEF_EXTRA_FRAC_BITS = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);
  localparam logic signed [BASE_W-1:0] BASE_RESET = BASE_W'(2560);
  localparam logic [THR_W-1:0] ENTER_RESET = THR_W'(1792);
  localparam logic [THR_W-1:0] EXIT_RESET  = THR_W'(1254);
  localparam logic [CONF_W-1:0] CONF_RESET = CONF_W'(3);
  localparam logic [CONF_W-1:0] CONF_MAX   = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM  = 3'd4;

  typedef enum logic [1:0] {
    SCENE_FLAT = 2'b00,
    SCENE_UP   = 2'b01,
    SCENE_DOWN = 2'b11
  } scene_t;

  typedef enum logic {
    LANE_WRAP    = 1'b0,
    LANE_REFLECT = 1'b1
  } lane_mode_t;

  typedef struct packed {
    logic load;
    logic update;
    logic first;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [BASE_W-1:0] baseline;
    logic [THR_W-1:0]         enter;
    logic [THR_W-1:0]         exit_thr;
    logic [CONF_W-1:0]        confirm;
  } scene_cfg_t;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic                      flag_changed;
    logic                      on_stairs;
    logic                      scene_changed;
    scene_t                    scene;
    logic signed [ANGLE_W-1:0] pitch_offset;
    logic signed [YAW_W-1:0]   yaw_out;
    logic signed [PITCH_W-1:0] pitch_out;
    logic signed [ROLL_W-1:0]  roll_out;
  } result_t;

  localparam int RESULT_W    = $bits(result_t);
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

endpackage

// ===== sv/tfsd_axis_lane.sv =====
module tfsd_axis_lane #(
  parameter int ANGLE_FRAC_BITS = tfsd_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int EXTRA_FRAC_BITS = tfsd_pkg::DEF_EXTRA_FRAC_BITS,
  parameter int IN_W            = tfsd_pkg::ROLL_W,
  parameter tfsd_pkg::lane_mode_t MODE = tfsd_pkg::LANE_WRAP
) (
  input  logic                                              clk,
  input  tfsd_pkg::lane_ctrl_t                              ctrl,
  input  logic signed [IN_W-1:0]                            sample,
  input  logic [tfsd_pkg::ALPHA_W-1:0]                      alpha,
  output logic signed [tfsd_pkg::ANGLE_W+EXTRA_FRAC_BITS-1:0] state
);
  import tfsd_pkg::*;

  localparam int SW = ANGLE_W + EXTRA_FRAC_BITS;
  localparam int PW = SW + ALPHA_W + 1;
  localparam int HALF_RAW = 180 << ANGLE_FRAC_BITS;
  localparam int LIM_RAW  = (MODE == LANE_REFLECT) ? (90 << ANGLE_FRAC_BITS) : HALF_RAW;

  localparam logic signed [IN_W+1:0] LIM_IN  = (IN_W+2)'(LIM_RAW);
  localparam logic signed [IN_W+1:0] LIM2_IN = (IN_W+2)'(2 * LIM_RAW);
  localparam logic signed [SW+1:0] HALF_S = (SW+2)'(HALF_RAW) <<< EXTRA_FRAC_BITS;
  localparam logic signed [SW+1:0] LIM_S  = (SW+2)'(LIM_RAW) <<< EXTRA_FRAC_BITS;
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);

  logic signed [IN_W+1:0]    sx;
  logic signed [IN_W+1:0]    raw_c;
  logic signed [ANGLE_W-1:0] raw_q;
  logic signed [SW-1:0]      target;
  logic signed [SW+1:0]      d0;
  logic signed [SW+1:0]      d1;
  logic signed [SW-1:0]      diff;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      rsum;
  logic signed [SW+1:0]      step;
  logic signed [SW+1:0]      f1;
  logic signed [SW+1:0]      f2;

  // Fold the raw sample into range before it enters the filter
  always_comb begin
    sx = (IN_W+2)'(sample);
    raw_c = sx;
    if (MODE == LANE_REFLECT) begin
      if (sx > LIM_IN) begin
        raw_c = LIM2_IN - sx;
      end else if (sx < -LIM_IN) begin
        raw_c = -LIM2_IN - sx;
      end
    end else begin
      if (sx > LIM_IN) begin
        raw_c = sx - LIM2_IN;
      end else if (sx < -LIM_IN) begin
        raw_c = sx + LIM2_IN;
      end
    end
  end

  // EMA step: shortest-way difference, gain, round, fold back
  always_comb begin
    target = SW'(raw_q) <<< EXTRA_FRAC_BITS;
    d0 = (SW+2)'(target) - (SW+2)'(state);
    d1 = d0;
    if (d0 > HALF_S) begin
      d1 = d0 - (HALF_S <<< 1);
    end else if (d0 < -HALF_S) begin
      d1 = d0 + (HALF_S <<< 1);
    end
    diff = SW'(d1);
    prod = $signed({1'b0, alpha}) * diff;
    rsum = prod + ROUND_HALF;
    step = (SW+2)'(rsum >>> 16);
    f1 = (SW+2)'(state) + step;
    f2 = f1;
    if (MODE == LANE_REFLECT) begin
      if (f1 > LIM_S) begin
        f2 = (LIM_S <<< 1) - f1;
      end else if (f1 < -LIM_S) begin
        f2 = -(LIM_S <<< 1) - f1;
      end
    end else begin
      if (f1 > LIM_S) begin
        f2 = f1 - (LIM_S <<< 1);
      end else if (f1 < -LIM_S) begin
        f2 = f1 + (LIM_S <<< 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      raw_q <= ANGLE_W'(raw_c);
    end
    if (ctrl.update) begin
      state <= ctrl.first ? target : SW'(f2);
    end
  end

endmodule

// ===== sv/tfsd_scene_merge.sv =====
module tfsd_scene_merge #(
  parameter int EXTRA_FRAC_BITS = tfsd_pkg::DEF_EXTRA_FRAC_BITS
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                advance,
  input  tfsd_pkg::scene_cfg_t                                cfg,
  input  logic signed [tfsd_pkg::ANGLE_W+EXTRA_FRAC_BITS-1:0] roll_state,
  input  logic signed [tfsd_pkg::ANGLE_W+EXTRA_FRAC_BITS-1:0] pitch_state,
  input  logic signed [tfsd_pkg::ANGLE_W+EXTRA_FRAC_BITS-1:0] yaw_state,
  output tfsd_pkg::result_t                                   result
);
  import tfsd_pkg::*;

  localparam int SW = ANGLE_W + EXTRA_FRAC_BITS;
  localparam logic signed [SW:0] HALF = (SW+1)'((1 << EXTRA_FRAC_BITS) >> 1);

  function automatic logic signed [ANGLE_W-1:0] round_angle(input logic signed [SW-1:0] st);
    logic signed [SW:0] s;
    s = (SW+1)'(st) + HALF;
    return ANGLE_W'(s >>> EXTRA_FRAC_BITS);
  endfunction

  scene_t            stable;
  scene_t            pending;
  logic [CONF_W-1:0] pend_cnt;
  logic              last_flag;

  scene_t                    stable_next;
  scene_t                    pending_next;
  logic [CONF_W-1:0]         pend_cnt_next;
  scene_t                    cand;
  logic                      changed;
  logic                      flag;
  logic signed [ANGLE_W-1:0] res_roll;
  logic signed [ANGLE_W-1:0] res_pitch;
  logic signed [ANGLE_W-1:0] res_yaw;
  logic signed [ANGLE_W:0]   dev;
  logic [THR_W-1:0]          ex_eff;
  logic signed [ANGLE_W:0]   ex_s;
  logic signed [ANGLE_W:0]   en_s;

  always_comb begin
    res_roll  = round_angle(roll_state);
    res_pitch = round_angle(pitch_state);
    res_yaw   = round_angle(yaw_state);
    dev = (ANGLE_W+1)'(cfg.baseline) - (ANGLE_W+1)'(res_pitch);
    ex_eff = (cfg.exit_thr > cfg.enter) ? cfg.enter : cfg.exit_thr;
    ex_s = $signed({2'b00, ex_eff});
    en_s = $signed({2'b00, cfg.enter});

    // Hysteresis: leave a stair scene on the exit level (capped at the enter level), enter on the enter level
    case (stable)
      SCENE_UP: begin
        cand = (dev > ex_s) ? SCENE_UP : SCENE_FLAT;
      end
      SCENE_DOWN: begin
        cand = (dev < -ex_s) ? SCENE_DOWN : SCENE_FLAT;
      end
      default: begin
        if (dev > en_s) begin
          cand = SCENE_UP;
        end else if (dev < -en_s) begin
          cand = SCENE_DOWN;
        end else begin
          cand = SCENE_FLAT;
        end
      end
    endcase

    // Debounce
    stable_next   = stable;
    pending_next  = cand;
    pend_cnt_next = '0;
    changed       = 1'b0;
    if (cand != stable) begin
      if (pending != cand) begin
        pend_cnt_next = CONF_W'(1);
      end else if (pend_cnt < CONF_MAX) begin
        pend_cnt_next = pend_cnt + CONF_W'(1);
      end else begin
        pend_cnt_next = pend_cnt;
      end
      if (pend_cnt_next >= cfg.confirm) begin
        stable_next   = cand;
        pend_cnt_next = '0;
        changed       = 1'b1;
      end
    end
    flag = (stable_next != SCENE_FLAT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= SCENE_FLAT;
      pending   <= SCENE_FLAT;
      pend_cnt  <= '0;
      last_flag <= 1'b0;
    end else if (advance) begin
      stable    <= stable_next;
      pending   <= pending_next;
      pend_cnt  <= pend_cnt_next;
      last_flag <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.roll_out      <= ROLL_W'(res_roll);
      result.pitch_out     <= PITCH_W'(res_pitch);
      result.yaw_out       <= YAW_W'(res_yaw);
      result.pitch_offset  <= ANGLE_W'(dev);
      result.scene         <= stable_next;
      result.scene_changed <= changed;
      result.on_stairs     <= flag;
      result.flag_changed  <= flag ^ last_flag;
    end
  end

endmodule

// ===== sv/tilt_filter_stair_detector.sv =====
// Tilt filter and stair-scene detector.
// Input stream (s_*): one transaction per IMU sample, roll/pitch/yaw in
// signed 1/128 degree. Output stream (m_*): one transaction per input
// transaction, in order: filtered angles, pitch deviation from baseline,
// stable scene (up/down/flat), scene-change and stairs-flag marks.
// Config port: cfg_we/cfg_index/cfg_data, one register per write, no
// read-back; write only while the block is drained.
// Pipeline: 3 stages (input fold, filter update, round + scene logic).
// A transaction passes the fold, filter and output registers in order.
// Throughput is one transaction per cycle while the receiver does not stall;
// the per-axis multiply-accumulate loop of the filter update sets the clock.
// Reset (rst, sync, high) empties the pipeline, restores register defaults,
// arms the first-sample load and returns the scene to flat.
// When the receiver stalls, the result holds in the output register and
// the upstream stages keep filling until all three are full; then s_tready
// drops. No transaction is dropped or repeated.
module tilt_filter_stair_detector #(
  parameter int ANGLE_FRAC_BITS = tfsd_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int EXTRA_FRAC_BITS = tfsd_pkg::DEF_EXTRA_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // roll_in[15:0], pitch_in[30:16], yaw_in[46:31], zero [47]
  input  logic [tfsd_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // roll_out[15:0], pitch_out[30:16], yaw_out[46:31], pitch_offset[62:47],
  // scene[64:63], scene_changed[65], on_stairs[66], flag_changed[67], zero
  output logic [tfsd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [tfsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfsd_pkg::ALPHA_W-1:0]        cfg_data
);
  import tfsd_pkg::*;

  localparam int SW = ANGLE_W + EXTRA_FRAC_BITS;
  localparam logic signed [BASE_W-1:0] QUARTER = BASE_W'(90 << ANGLE_FRAC_BITS);

  // Config registers; alpha, baseline and confirm are stored already saturated
  logic [ALPHA_W-1:0] alpha;
  scene_cfg_t         scfg;

  logic signed [BASE_W-1:0] base_wr;
  always_comb base_wr = $signed(cfg_data[BASE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= ALPHA_RESET;
      scfg.baseline <= BASE_RESET;
      scfg.enter    <= ENTER_RESET;
      scfg.exit_thr <= EXIT_RESET;
      scfg.confirm  <= CONF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA: begin
          alpha <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
        end
        CFG_BASELINE: begin
          if (base_wr > QUARTER) begin
            scfg.baseline <= QUARTER;
          end else if (base_wr < -QUARTER) begin
            scfg.baseline <= -QUARTER;
          end else begin
            scfg.baseline <= base_wr;
          end
        end
        CFG_ENTER: begin
          scfg.enter <= cfg_data[THR_W-1:0];
        end
        CFG_EXIT: begin
          scfg.exit_thr <= cfg_data[THR_W-1:0];
        end
        CFG_CONFIRM: begin
          // zero acts as one
          scfg.confirm <= (cfg_data[CONF_W-1:0] == '0) ? CONF_W'(1) : cfg_data[CONF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Stage valids and elastic handshake
  logic v0;
  logic v1;
  logic rdy0;
  logic rdy1;
  logic rdy2;
  logic adv0;
  logic adv1;
  logic adv2;
  logic first_sample;

  assign rdy2 = !m_tvalid || m_tready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign adv0 = s_tvalid && rdy0;
  assign adv1 = v0 && rdy1;
  assign adv2 = v1 && rdy2;
  assign s_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      m_tvalid     <= 1'b0;
      first_sample <= 1'b1;
    end else begin
      if (rdy0) begin
        v0 <= s_tvalid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        m_tvalid <= v1;
      end
      if (adv1) begin
        first_sample <= 1'b0;
      end
    end
  end

  lane_ctrl_t lctrl;
  assign lctrl.load   = adv0;
  assign lctrl.update = adv1;
  assign lctrl.first  = first_sample;

  logic signed [SW-1:0] roll_state;
  logic signed [SW-1:0] pitch_state;
  logic signed [SW-1:0] yaw_state;

  // One lane per axis
  tfsd_axis_lane #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS),
    .IN_W(ROLL_W),
    .MODE(LANE_WRAP)
  ) u_roll (
    .clk(clk),
    .ctrl(lctrl),
    .sample($signed(s_tdata[ROLL_W-1:0])),
    .alpha(alpha),
    .state(roll_state)
  );

  tfsd_axis_lane #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS),
    .IN_W(PITCH_W),
    .MODE(LANE_REFLECT)
  ) u_pitch (
    .clk(clk),
    .ctrl(lctrl),
    .sample($signed(s_tdata[ROLL_W+PITCH_W-1:ROLL_W])),
    .alpha(alpha),
    .state(pitch_state)
  );

  tfsd_axis_lane #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS),
    .IN_W(YAW_W),
    .MODE(LANE_WRAP)
  ) u_yaw (
    .clk(clk),
    .ctrl(lctrl),
    .sample($signed(s_tdata[ROLL_W+PITCH_W+YAW_W-1:ROLL_W+PITCH_W])),
    .alpha(alpha),
    .state(yaw_state)
  );

  // Merge: rounding, deviation, hysteresis and debounce
  result_t res;

  tfsd_scene_merge #(
    .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)
  ) u_merge (
    .clk(clk),
    .rst(rst),
    .advance(adv2),
    .cfg(scfg),
    .roll_state(roll_state),
    .pitch_state(pitch_state),
    .yaw_state(yaw_state),
    .result(res)
  );

  assign m_tdata = {(OUT_TDATA_W-RESULT_W)'(0), res};

  // Stairs flag always mirrors the stable scene
  a_flag_scene: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.on_stairs == (res.scene != SCENE_FLAT)))
    else $error("on_stairs does not match scene");

  // Scene switches only between flat and a stair scene, so both marks agree
  a_marks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.scene_changed == res.flag_changed))
    else $error("scene_changed and flag_changed disagree");

  // First-sample load is consumed only by a filter update
  a_first: assert property (@(posedge clk) disable iff (rst)
    $fell(first_sample) |-> $past(adv1))
    else $error("first_sample cleared without filter update");

  // Reflected pitch never leaves +-90 degrees
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.pitch_out <= QUARTER) && (res.pitch_out >= -QUARTER)))
    else $error("pitch_out out of range");

endmodule
